FILE: src/sobel_edge_magnitude_rgb_assert.svh
// Assertion macros shared by the Sobel edge magnitude block.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SOBEL_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SOBEL_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/sobel_pkg.sv
// Package with the types and constants of the Sobel edge magnitude block.
package sobel_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   localparam int CHAN_W = 8;
   localparam int PIX_W  = 3 * CHAN_W;
   localparam int LINE_W = 2 * PIX_W;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int FW_W   = 11;
   localparam int FH_W   = 13;
   localparam int ROW_W  = 13;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [FH_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [FW_W-1:0] WIDTH_MAX    = FW_W'(MAX_WIDTH);
   localparam logic [FH_W-1:0] HEIGHT_MAX   = FH_W'(MAX_HEIGHT);

   // Magnitude arithmetic: the radicand is four times Gx^2+Gy^2.
   localparam int ABS_W   = 10;
   localparam int SQ_W    = 2 * ABS_W;
   localparam int RAD_W   = 24;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int STEP_W  = $clog2(ROOT_W);
   localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);

   typedef struct packed {
      logic              req_type;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_item_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              row_end;
      logic              frame_end;
   } rsp_item_type;

   typedef logic [2:0][2:0][CHAN_W-1:0] chan_taps_type;

endpackage

FILE: src/sobel_ram.sv
// Generic single-port-write, registered-read synchronous RAM.
module sobel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/sobel_mag.sv
// Gradient magnitude of one colour channel: Sobel sums, squares and a rounded square root.
module sobel_mag (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  sobel_pkg::chan_taps_type      taps,
   output logic                          done,
   output logic [sobel_pkg::CHAN_W-1:0]  mag
);
   import sobel_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_ABS  = 6'b000010,
      S_SQ   = 6'b000100,
      S_SUM  = 6'b001000,
      S_ROOT = 6'b010000,
      S_FIN  = 6'b100000
   } mag_state_type;

   mag_state_type     state_ff, state_in;
   logic [ABS_W-1:0]  ax_ff, ay_ff;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] q_ff, q_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [ABS_W-1:0]  pos_x, neg_x, pos_y, neg_y;
   logic [ABS_W:0]    gx, gy;
   logic [REM_W+1:0]  rem_sh, trial, diff;
   logic [ROOT_W:0]   rounded;

   always_comb begin
      pos_x = ABS_W'(taps[0][2]) + {taps[1][2], 1'b0} + ABS_W'(taps[2][2]);
      neg_x = ABS_W'(taps[0][0]) + {taps[1][0], 1'b0} + ABS_W'(taps[2][0]);
      pos_y = ABS_W'(taps[2][0]) + {taps[2][1], 1'b0} + ABS_W'(taps[2][2]);
      neg_y = ABS_W'(taps[0][0]) + {taps[0][1], 1'b0} + ABS_W'(taps[0][2]);
      gx    = {1'b0, pos_x} - {1'b0, neg_x};
      gy    = {1'b0, pos_y} - {1'b0, neg_y};
   end

   // One result bit per step of the restoring square root.
   assign rem_sh = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial  = {2'b00, q_ff, 2'b01};
   assign diff   = rem_sh - trial;

   always_comb begin
      state_in = state_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_ABS;
            end
         end
         S_ABS: begin
            state_in = S_SQ;
         end
         S_SQ: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            rad_in   = {1'b0, ({1'b0, sqx_ff} + {1'b0, sqy_ff}), 2'b00};
            rem_in   = '0;
            q_in     = '0;
            step_in  = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (rem_sh >= trial) begin
               rem_in = diff[REM_W-1:0];
               q_in   = {q_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[REM_W-1:0];
               q_in   = {q_ff[ROOT_W-2:0], 1'b0};
            end
            if (step_ff == ROOT_LAST) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_ABS) begin
         ax_ff <= gx[ABS_W] ? ABS_W'(-gx) : gx[ABS_W-1:0];
         ay_ff <= gy[ABS_W] ? ABS_W'(-gy) : gy[ABS_W-1:0];
      end
      if (state_ff == S_SQ) begin
         sqx_ff <= ax_ff * ax_ff;
         sqy_ff <= ay_ff * ay_ff;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      step_ff <= step_in;
   end

   // The root of four times the sum, halved with rounding up, is the rounded root.
   assign rounded = ({1'b0, q_ff} + 1'b1) >> 1;
   assign mag     = (rounded > (ROOT_W+1)'(255)) ? 8'd255 : rounded[CHAN_W-1:0];
   assign done    = (state_ff == S_FIN);

endmodule

FILE: src/sobel_edge_magnitude_rgb.sv
// Top level of the Sobel edge magnitude block: line stores, window, counters, output register.
//
// Pixels enter on the req_ channel (req_valid, req_stall, req_data) in raster order;
// each colour channel is filtered with the 3x3 Sobel kernels and the rounded gradient
// magnitude, clamped to 255, leaves on the rsp_ channel. The result of a pixel leaves
// once the pixel one row below and one column to the right (in the last column: the first
// pixel two rows below) has been taken, so the first frame_width+1 requests of a frame give
// no result; after each frame the host sends frame_width+1 pad requests to flush the last row.
// frame_width and frame_height are written through csr_write, csr_index and csr_wdata;
// the host must write them only while the block is idle, as the block does not enforce it.
// One request is worked on at a time. A request without result returns the block to idle
// after the line read; one with a result waits for the twelve steps of the square-root unit,
// and the next request can be taken in the cycle in which its result appears on rsp_valid.
// Both line stores share one 1024-entry RAM, read at acceptance and written back in
// the next cycle.
// Synchronous reset returns the state, counters, window, frame size and output valid flag to
// their defaults; the RAM is not cleared, as entries are only used once written.
// A stalled result waits in the output register; the block then holds the next
// finished result and takes no further request until the register frees.
`include "sobel_edge_magnitude_rgb_assert.svh"

module sobel_edge_magnitude_rgb (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sobel_pkg::req_item_type             req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sobel_pkg::rsp_item_type             rsp_data,
   input  logic                                csr_write,
   input  logic [sobel_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sobel_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sobel_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_CALC = 4'b0100,
      ST_OUT  = 4'b1000
   } top_state_type;

   top_state_type                 state_ff, state_in;
   logic [FW_W-1:0]               width_ff, width_in;
   logic [FH_W-1:0]               height_ff, height_in;
   logic [COL_W-1:0]              in_col_ff, in_col_in;
   logic [ROW_W-1:0]              in_row_ff, in_row_in;
   logic [COL_W-1:0]              cur_col_ff;
   logic [ROW_W-1:0]              cur_row_ff;
   logic [PIX_W-1:0]              pix_ff;
   logic [2:0][2:0][PIX_W-1:0]    win_ff, win_in;
   logic [2:0][2:0][PIX_W-1:0]    tap_ff, tap_in;
   logic                          row_end_ff, frame_end_ff, row_end_in, frame_end_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_item_type                  rsp_data_ff;

   logic                          accept, wrap, emit_a, emit_b, emit, load_out;
   logic [COL_W-1:0]              adj_col;
   logic [ROW_W-1:0]              adj_row;
   logic [PIX_W-1:0]              adj_pix, top_pix, mid_pix;
   logic [2:0][PIX_W-1:0]         new_col;
   logic [ROW_W-1:0]              out_row;
   logic [COL_W-1:0]              out_col;
   logic [2:0]                    row_ok, col_ok;
   logic [FW_W:0]                 next_col;
   logic [FW_W-1:0]               wr_width;
   logic [FH_W-1:0]               wr_height;
   logic [LINE_W-1:0]             line_rd;
   chan_taps_type                 red_taps, green_taps, blue_taps;
   logic                          red_done, green_done, blue_done;
   logic [CHAN_W-1:0]             red_mag, green_mag, blue_mag;

   // Configuration: zero and values above the maximum are clamped; width uses csr_wdata[10:0].
   always_comb begin
      wr_width  = csr_wdata[FW_W-1:0];
      wr_height = csr_wdata[FH_W-1:0];
      if (wr_width == '0) begin
         wr_width = FW_W'(1);
      end else if (wr_width > WIDTH_MAX) begin
         wr_width = WIDTH_MAX;
      end
      if (wr_height == '0) begin
         wr_height = FH_W'(1);
      end else if (wr_height > HEIGHT_MAX) begin
         wr_height = HEIGHT_MAX;
      end
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = wr_width;
            CSR_FRAME_HEIGHT: height_in = wr_height;
            default: ;
         endcase
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // A column beyond the current width, left by a width change, wraps first.
   always_comb begin
      wrap    = ({1'b0, in_col_ff} >= width_ff);
      adj_col = wrap ? '0 : in_col_ff;
      adj_row = wrap ? in_row_ff + 1'b1 : in_row_ff;
      adj_pix = '0;
      if (!req_data.req_type && (adj_row < height_ff)) begin
         adj_pix = {req_data.red_in, req_data.green_in, req_data.blue_in};
      end
   end

   sobel_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (cur_col_ff),
      .wr_data ({mid_pix, pix_ff}),
      .rd_en   (accept),
      .rd_addr (adj_col),
      .rd_data (line_rd)
   );

   assign top_pix = line_rd[LINE_W-1 -: PIX_W];
   assign mid_pix = line_rd[PIX_W-1:0];
   assign new_col = {pix_ff, mid_pix, top_pix};

   // Window update, result selection and edge masking for the item in hand.
   always_comb begin
      emit_a   = (cur_col_ff == '0) && (cur_row_ff >= ROW_W'(2));
      emit_b   = (cur_col_ff != '0) && (cur_row_ff >= ROW_W'(1));
      emit     = emit_a || emit_b;
      out_row  = emit_a ? cur_row_ff - ROW_W'(2) : cur_row_ff - ROW_W'(1);
      out_col  = emit_a ? COL_W'(width_ff - 1'b1) : cur_col_ff - 1'b1;
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
         win_in[r][2] = new_col[r];
         tap_in[r][0] = win_ff[r][1];
         tap_in[r][1] = win_ff[r][2];
         tap_in[r][2] = emit_a ? '0 : new_col[r];
         if (emit_a) begin
            tap_in[r][0] = win_ff[r][1];
         end else begin
            tap_in[r][0] = win_ff[r][1];
         end
      end
      if (!emit_a) begin
         for (int r = 0; r < 3; r++) begin
            tap_in[r][0] = win_ff[r][1];
            tap_in[r][1] = win_ff[r][2];
            tap_in[r][2] = new_col[r];
         end
      end
      for (int k = 0; k < 3; k++) begin
         row_ok[k] = (({1'b0, out_row} + (ROW_W+1)'(k)) != '0) &&
                     (({1'b0, out_row} + (ROW_W+1)'(k) - 1'b1) < {1'b0, height_ff});
         col_ok[k] = (({2'b00, out_col} + (COL_W+2)'(k)) != '0) &&
                     (({2'b00, out_col} + (COL_W+2)'(k) - 1'b1) < {1'b0, width_ff});
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (!(row_ok[r] && col_ok[c])) begin
               tap_in[r][c] = '0;
            end
         end
      end
      row_end_in   = ({1'b0, out_col} == (width_ff - 1'b1));
      frame_end_in = row_end_in && (out_row == (height_ff - 1'b1));
   end

   // Input counters advance, or close the frame after the flush item.
   always_comb begin
      next_col  = {2'b00, cur_col_ff} + 1'b1;
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (state_ff == ST_READ) begin
         if ({1'b0, cur_row_ff} >= ({1'b0, height_ff} + 1'b1)) begin
            in_col_in = '0;
            in_row_in = '0;
         end else if (next_col >= {1'b0, width_ff}) begin
            in_col_in = '0;
            in_row_in = cur_row_ff + 1'b1;
         end else begin
            in_col_in = next_col[COL_W-1:0];
            in_row_in = cur_row_ff;
         end
      end
   end

   assign load_out = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = emit ? ST_CALC : ST_IDLE;
         end
         ST_CALC: begin
            if (red_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         win_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_READ) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_col_ff <= adj_col;
         cur_row_ff <= adj_row;
         pix_ff     <= adj_pix;
      end
      if (state_ff == ST_READ) begin
         tap_ff       <= tap_in;
         row_end_ff   <= row_end_in;
         frame_end_ff <= frame_end_in;
      end
      if (load_out) begin
         rsp_data_ff.red_out   <= red_mag;
         rsp_data_ff.green_out <= green_mag;
         rsp_data_ff.blue_out  <= blue_mag;
         rsp_data_ff.row_end   <= row_end_ff;
         rsp_data_ff.frame_end <= frame_end_ff;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            red_taps[r][c]   = tap_ff[r][c][PIX_W-1 -: CHAN_W];
            green_taps[r][c] = tap_ff[r][c][2*CHAN_W-1 -: CHAN_W];
            blue_taps[r][c]  = tap_ff[r][c][CHAN_W-1:0];
         end
      end
   end

   sobel_mag u_mag_red (
      .clock (clock),
      .reset (reset),
      .start ((state_ff == ST_READ) && emit),
      .taps  (red_taps),
      .done  (red_done),
      .mag   (red_mag)
   );

   sobel_mag u_mag_green (
      .clock (clock),
      .reset (reset),
      .start ((state_ff == ST_READ) && emit),
      .taps  (green_taps),
      .done  (green_done),
      .mag   (green_mag)
   );

   sobel_mag u_mag_blue (
      .clock (clock),
      .reset (reset),
      .start ((state_ff == ST_READ) && emit),
      .taps  (blue_taps),
      .done  (blue_done),
      .mag   (blue_mag)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SOBEL_ASSERT_NXT(a_accept_reads, accept, state_ff == ST_READ, "request not followed by line read")
   `SOBEL_ASSERT_IMP(a_lanes_locked, red_done, green_done && blue_done, "channel units out of step")
   `SOBEL_ASSERT_IMP(a_done_in_calc, red_done, state_ff == ST_CALC, "magnitude finished outside calc")

endmodule

FILE: tb/sv/sobel_edge_checker.sv
// Checker for the Sobel edge block: watches all ports, predicts each result and compares.
module sobel_edge_checker
   import sobel_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_item_type          req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_item_type          rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    pending_count,
   output int                    edges_checked
);

   logic [FW_W-1:0]   width_reg;
   logic [FH_W-1:0]   height_reg;
   logic [PIX_W-1:0]  upper_line [MAX_WIDTH];
   logic [PIX_W-1:0]  lower_line [MAX_WIDTH];
   logic [8:0][PIX_W-1:0] window;
   int                in_col;
   int                in_row;
   rsp_item_type      expected_edges [$];

   function automatic logic [CHAN_W-1:0] edge_magnitude(logic [8:0][PIX_W-1:0] taps, int shift);
      int p [9];
      int gx;
      int gy;
      int s;
      int k;
      for (int i = 0; i < 9; i++) p[i] = (taps[i] >> shift) & 8'hff;
      gx = (p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6]);
      gy = (p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2]);
      s = gx * gx + gy * gy;
      k = 0;
      while (k < 256 && (k + 1) * (k + 1) <= s) k++;
      if (k < 256 && s - k * k > k) k++;
      return (k > 255) ? 8'd255 : CHAN_W'(k);
   endfunction

   task automatic predict_edge(input req_item_type item);
      int w;
      int h;
      int ic;
      int ir;
      int orow;
      int ocol;
      bit emit;
      logic [PIX_W-1:0] v;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [8:0][PIX_W-1:0] taps;
      rsp_item_type res;
      w = (width_reg < 1) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
      h = (height_reg < 1) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
      ic = in_col;
      ir = in_row;
      emit = 0;
      orow = 0;
      ocol = 0;
      taps = '0;
      if (ic >= w) begin
         ic = 0;
         ir++;
      end
      v = (!item.req_type && ir < h) ? {item.red_in, item.green_in, item.blue_in} : '0;
      top = upper_line[ic];
      mid = lower_line[ic];
      upper_line[ic] = mid;
      lower_line[ic] = v;
      // At column zero the last pixel of the row two above is finished; its right taps are off-frame.
      if (ic == 0 && ir >= 2) begin
         orow = ir - 2;
         ocol = w - 1;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               taps[r * 3 + c] = (c < 2) ? window[r * 3 + c + 1] : '0;
         emit = 1;
      end
      for (int r = 0; r < 3; r++) begin
         window[r * 3 + 0] = window[r * 3 + 1];
         window[r * 3 + 1] = window[r * 3 + 2];
      end
      window[2] = top;
      window[5] = mid;
      window[8] = v;
      if (ic != 0 && ir >= 1) begin
         orow = ir - 1;
         ocol = ic - 1;
         taps = window;
         emit = 1;
      end
      if (emit) begin
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               if (orow + r < 1 || orow + r - 1 >= h || ocol + c < 1 || ocol + c - 1 >= w)
                  taps[r * 3 + c] = '0;
         res.red_out   = edge_magnitude(taps, 16);
         res.green_out = edge_magnitude(taps, 8);
         res.blue_out  = edge_magnitude(taps, 0);
         res.row_end   = (ocol == w - 1);
         res.frame_end = (ocol == w - 1 && orow == h - 1);
         expected_edges.push_back(res);
      end
      if (ir >= h + 1) begin
         in_col = 0;
         in_row = 0;
      end else begin
         ic++;
         if (ic >= w) begin
            ic = 0;
            ir++;
         end
         in_col = ic;
         in_row = ir;
      end
   endtask

   initial begin
      error_count = 0;
      edges_checked = 0;
   end

   assign pending_count = expected_edges.size();

   always @(posedge clock) begin
      if (reset) begin
         width_reg <= WIDTH_RESET;
         height_reg <= HEIGHT_RESET;
         window = '0;
         in_col = 0;
         in_row = 0;
         expected_edges.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_FRAME_WIDTH) width_reg <= FW_W'(csr_wdata);
            else if (csr_index == CSR_FRAME_HEIGHT) height_reg <= FH_W'(csr_wdata);
         end
         if (req_valid && !req_stall) predict_edge(req_data);
         if (rsp_valid && !rsp_stall) begin
            edges_checked++;
            if (expected_edges.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: unexpected result %p", rsp_data);
            end else if (expected_edges[0] !== rsp_data) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected %p, got %p", expected_edges[0], rsp_data);
               void'(expected_edges.pop_front());
            end else begin
               void'(expected_edges.pop_front());
            end
         end
      end
   end

endmodule

FILE: tb/sv/testbench.sv
// Top of the Sobel edge testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
   import sobel_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_item_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_item_type          rsp_data;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    error_count;
   int                    pending_count;
   int                    edges_checked;
   int                    cycle_count;
   int                    sent_count;
   int                    frame_count;
   int                    send_idle_pct;
   int                    recv_stall_pct;
   int                    hold_request;
   int                    hold_seen;
   int                    hold_left;

   sobel_edge_magnitude_rgb uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   sobel_edge_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .pending_count(pending_count),
      .edges_checked(edges_checked)
   );

   initial clock = 0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The receiver stalls at random, and holds off for a long stretch whenever asked.
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < recv_stall_pct);
      end
   end

   task automatic send_request(input req_item_type item);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      // A request with no result may still be in flight.
      repeat (30) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // pattern: 0 random, 1 all full scale, 2 red/green checkerboard, blue every third pixel.
   task automatic run_frame(input int w_reg, input int h_reg, input int pattern, input int noise_pct);
      int w;
      int h;
      req_item_type item;
      w = (w_reg < 1) ? 1 : ((w_reg > MAX_WIDTH) ? MAX_WIDTH : w_reg);
      h = (h_reg < 1) ? 1 : ((h_reg > MAX_HEIGHT) ? MAX_HEIGHT : h_reg);
      case (frame_count % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
         default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      write_register(CSR_FRAME_WIDTH, w_reg);
      write_register(CSR_FRAME_HEIGHT, h_reg);
      for (int i = 0; i < w * h + w + 1; i++) begin
         item = req_item_type'($urandom);
         if (pattern == 1) begin
            item = '1;
         end else if (pattern == 2) begin
            item.red_in = (((i % w) + (i / w)) % 2) ? 8'hff : 8'h00;
            item.green_in = ~item.red_in;
            item.blue_in = (i % 3 == 0) ? 8'hff : 8'h00;
         end
         // Inside the frame a pad comes with probability noise_pct; in the flush a real pixel does.
         if (i < w * h) item.req_type = ($urandom_range(99, 0) < noise_pct);
         else item.req_type = !($urandom_range(99, 0) < noise_pct);
         send_request(item);
      end
      frame_count++;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = CSR_FRAME_WIDTH;
      csr_wdata = '0;
      rsp_stall = 1'b0;
      cycle_count = 0;
      sent_count = 0;
      frame_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 0;
      hold_seen = 0;
      hold_left = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_frame(1, 1, 1, 0);
      run_frame(0, 0, 1, 100);
      run_frame(3, 3, 2, 0);
      run_frame(2, 2, 1, 50);

      while (sent_count < 950) begin
         if (frame_count == 8) hold_request++;
         run_frame($urandom_range(12, 1), $urandom_range(10, 1), 0, 8);
      end
      run_frame(100, 3, 0, 5);
      run_frame(5, 4, 0, 50);

      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d requests over %0d frames, %0d results checked.",
               sent_count, frame_count, edges_checked);
      $display("Frames from a zero-size setting up to 100 pixels wide, with pads, gaps and stalls.");
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sobel_edge_magnitude_rgb.f
+incdir+src
src/sobel_pkg.sv
src/sobel_ram.sv
src/sobel_mag.sv
src/sobel_edge_magnitude_rgb.sv
tb/sv/sobel_edge_checker.sv
tb/sv/testbench.sv
